/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Status codes carried with each result word
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_DONE      = 3'd1;
  localparam logic [2:0] STAT_BAD_ESC   = 3'd2;
  localparam logic [2:0] STAT_BAD_HEX   = 3'd3;
  localparam logic [2:0] STAT_BAD_SURR  = 3'd4;
  localparam logic [2:0] STAT_CTRL_CHAR = 3'd5;
  localparam logic [2:0] STAT_NO_QUOTE  = 3'd6;

  // Results caused by one input byte: up to four words
  typedef struct packed {
    logic [3:0][7:0] data;      // data[0] leaves first
    logic [1:0]      last_idx;  // index of the final word
    logic            has_byte;  // words carry decoded bytes
    logic [2:0]      status;
  } bundle_t;

endpackage

/* rtl/jsu_step.sv */
// ----------------------------------------------------------------------------
// jsu_step
// Parser state and per-byte decode: escapes, hex, surrogates, UTF-8 encode.
// ----------------------------------------------------------------------------
module jsu_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  output logic              load_o,
  output jsu_pkg::bundle_t  bundle_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_BSL  = 3'd4,
    PH_U    = 3'd5,
    PH_HEX2 = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  digits_q, digits_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hs_q, hs_d;

  // Hex digit value; bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {["0":"9"]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {["a":"f"]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {["A":"F"]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic jsu_pkg::bundle_t status_word(input logic [2:0] code);
    jsu_pkg::bundle_t b;
    b        = '0;
    b.status = code;
    return b;
  endfunction

  function automatic jsu_pkg::bundle_t byte_word(input logic [7:0] v);
    jsu_pkg::bundle_t b;
    b          = '0;
    b.data[0]  = v;
    b.has_byte = 1'b1;
    b.status   = jsu_pkg::STAT_OK;
    return b;
  endfunction

  // UTF-8 of a code point below 0x10000
  function automatic jsu_pkg::bundle_t enc16(input logic [15:0] v);
    jsu_pkg::bundle_t b;
    b          = '0;
    b.has_byte = 1'b1;
    b.status   = jsu_pkg::STAT_OK;
    if (v <= 16'h007F) begin
      b.data[0]  = v[7:0];
      b.last_idx = 2'd0;
    end else if (v <= 16'h07FF) begin
      b.data[0]  = {3'b110, v[10:6]};
      b.data[1]  = {2'b10, v[5:0]};
      b.last_idx = 2'd1;
    end else begin
      b.data[0]  = {4'b1110, v[15:12]};
      b.data[1]  = {2'b10, v[11:6]};
      b.data[2]  = {2'b10, v[5:0]};
      b.last_idx = 2'd2;
    end
    return b;
  endfunction

  // UTF-8 of a supplementary code point (always four bytes)
  function automatic jsu_pkg::bundle_t enc21(input logic [20:0] cp);
    jsu_pkg::bundle_t b;
    b          = '0;
    b.has_byte = 1'b1;
    b.status   = jsu_pkg::STAT_OK;
    b.data[0]  = {5'b11110, cp[20:18]};
    b.data[1]  = {2'b10, cp[17:12]};
    b.data[2]  = {2'b10, cp[11:6]};
    b.data[3]  = {2'b10, cp[5:0]};
    b.last_idx = 2'd3;
    return b;
  endfunction

  logic [4:0]  hex;
  logic [15:0] acc_new;
  logic [20:0] cp;

  assign hex     = hexval(in_byte_i);
  assign acc_new = {acc_q[11:0], hex[3:0]};
  assign cp      = {1'b0, hs_q, acc_new[9:0]} + 21'h010000;

  // Next state and results of the byte at the input
  always_comb begin
    phase_d  = phase_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    hs_d     = hs_q;
    load_o   = 1'b0;
    bundle_o = '0;
    case (phase_q)
      PH_STR: begin
        if (in_byte_i == "\"") begin
          phase_d  = PH_IDLE;
          load_o   = 1'b1;
          bundle_o = status_word(jsu_pkg::STAT_DONE);
        end else if (in_byte_i == "\\") begin
          phase_d = PH_ESC;
        end else if (in_byte_i == 8'h00) begin
          phase_d  = PH_IDLE;
          load_o   = 1'b1;
          bundle_o = status_word(jsu_pkg::STAT_NO_QUOTE);
        end else if (in_byte_i < 8'h20) begin
          phase_d  = PH_IDLE;
          load_o   = 1'b1;
          bundle_o = status_word(jsu_pkg::STAT_CTRL_CHAR);
        end else begin
          load_o   = 1'b1;
          bundle_o = byte_word(in_byte_i);
        end
      end
      PH_ESC: begin
        phase_d = PH_STR;
        load_o  = 1'b1;
        case (in_byte_i)
          "\"":    bundle_o = byte_word(8'h22);
          "\\":    bundle_o = byte_word(8'h5C);
          "/":     bundle_o = byte_word(8'h2F);
          "b":     bundle_o = byte_word(8'h08);
          "f":     bundle_o = byte_word(8'h0C);
          "n":     bundle_o = byte_word(8'h0A);
          "r":     bundle_o = byte_word(8'h0D);
          "t":     bundle_o = byte_word(8'h09);
          "u": begin
            phase_d  = PH_HEX1;
            load_o   = 1'b0;
            digits_d = '0;
            acc_d    = '0;
          end
          default: begin
            phase_d  = PH_IDLE;
            bundle_o = status_word(jsu_pkg::STAT_BAD_ESC);
          end
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        if (!hex[4]) begin
          phase_d  = PH_IDLE;
          load_o   = 1'b1;
          bundle_o = status_word(jsu_pkg::STAT_BAD_HEX);
        end else begin
          acc_d    = acc_new;
          digits_d = digits_q + 2'd1;
          if (digits_q == 2'd3) begin
            if (phase_q == PH_HEX1) begin
              if (acc_new inside {[16'hD800:16'hDBFF]}) begin
                hs_d    = acc_new[9:0];
                phase_d = PH_BSL;
              end else begin
                phase_d  = PH_STR;
                load_o   = 1'b1;
                bundle_o = enc16(acc_new);
              end
            end else begin
              load_o = 1'b1;
              if (acc_new inside {[16'hDC00:16'hDFFF]}) begin
                phase_d  = PH_STR;
                bundle_o = enc21(cp);
              end else begin
                phase_d  = PH_IDLE;
                bundle_o = status_word(jsu_pkg::STAT_BAD_SURR);
              end
            end
          end
        end
      end
      PH_BSL: begin
        if (in_byte_i == "\\") begin
          phase_d = PH_U;
        end else begin
          phase_d  = PH_IDLE;
          load_o   = 1'b1;
          bundle_o = status_word(jsu_pkg::STAT_BAD_SURR);
        end
      end
      PH_U: begin
        if (in_byte_i == "u") begin
          phase_d  = PH_HEX2;
          digits_d = '0;
          acc_d    = '0;
        end else begin
          phase_d  = PH_IDLE;
          load_o   = 1'b1;
          bundle_o = status_word(jsu_pkg::STAT_BAD_SURR);
        end
      end
      default: begin
        // idle: wait for the opening quote
        phase_d = (in_byte_i == "\"") ? PH_STR : PH_IDLE;
      end
    endcase
    if (!accept_i) begin
      load_o = 1'b0;
    end
  end

  // Parser state advances on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      digits_q <= '0;
      acc_q    <= '0;
      hs_q     <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      hs_q     <= hs_d;
    end
  end

endmodule

/* rtl/jsu_emit.sv */
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds one byte's results, sends one word each ready cycle.
// ----------------------------------------------------------------------------
module jsu_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jsu_pkg::bundle_t  bundle_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              has_byte_o,
  output logic [2:0]        status_o,
  output logic              last_o
);

  jsu_pkg::bundle_t bund_q;
  logic             valid_q;
  logic [1:0]       idx_q;
  logic             fire;
  logic             at_last;

  assign at_last     = (idx_q == bund_q.last_idx);
  assign fire        = valid_q && out_ready_i;
  // room for a new byte when empty or the final word leaves now
  assign free_o      = !valid_q || (out_ready_i && at_last);

  assign out_valid_o = valid_q;
  assign out_byte_o  = bund_q.data[idx_q];
  assign has_byte_o  = bund_q.has_byte;
  assign status_o    = bund_q.status;
  assign last_o      = at_last;

  // Control: valid flag and word index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bund_q <= bundle_i;
    end
  end

  // A load never overwrites words still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || (out_ready_i && at_last)))
    else $error("result register overwritten");

  // The index never runs past the final word
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= bund_q.last_idx))
    else $error("word index beyond final word");

  // A stalled word keeps its place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i && !load_i) |=> (valid_q && $stable(idx_q)))
    else $error("word index moved while stalled");

  // Status words are single and carry no byte
  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !bund_q.has_byte) |-> (bund_q.last_idx == 2'd0 && out_byte_o == 8'h00))
    else $error("malformed status word");

endmodule

/* rtl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streams JSON text bytes, decodes string escapes and emits UTF-8 words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_byte_i
//  out     | output    | out_valid_o/out_ready_i | out_byte_o has_byte_o status_o last_o
//
//  A text byte is decoded in the cycle it is accepted; its words appear on
//  the output from the next cycle on, one word per cycle while out_ready_i is high.
//  A byte's words occupy the result register until its final word leaves;
//  that register sets the rate.
//  Every byte, also one that gives no word, waits until the register is
//  empty or its final word leaves in the same cycle.
//  in_ready_o follows out_ready_i combinationally when the final word leaves.
//  Reset returns the parser to idle and empties the result register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  jsu_pkg::bundle_t bundle;
  logic             load;
  logic             free;
  logic             accept;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  jsu_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .load_o    (load),
    .bundle_o  (bundle)
  );

  jsu_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
